// File: design/int8_matrix_multiply_assert.svh
// Assertion macros for the int8 matrix multiply block.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef INT8_MATRIX_MULTIPLY_ASSERT_SVH
`define INT8_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imm: same-cycle check failed");

// next-cycle implication, disabled in reset
`define IMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imm: next-cycle check failed");

`endif

// File: design/imm_pkg.sv
// Shared types and constants for the int8 matrix multiply block.
// No dependencies; used by imm_seq and int8_matrix_multiply.
package imm_pkg;

  localparam int ELEM_W    = 8;
  localparam int SUM_W     = 32;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_LENGTH  = 2'd0,
    CFG_OUTPUT_COUNT  = 2'd1,
    CFG_WEIGHT_LAYOUT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_ACT    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MAC
  } seq_state_e;

  typedef struct packed {
    logic             w_load;    // weight transaction writes the store
    logic             act_take;  // activation transaction latched
    logic             rd_issue;  // weight and accumulator reads issued
    logic             mac_en;    // read data valid, MAC step this cycle
    logic             row_end;   // MAC step belongs to the row's final element
    logic [IDX_W-1:0] j;         // output feature in process
    logic             j_last;    // j is the final output feature
  } ctrl_t;

endpackage

// File: design/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/imm_seq.sv
// Sequencer: load position, activation position, weight addressing and
// the per-output read/MAC stepping. Depends on imm_pkg.
module imm_seq #(
  parameter int MAX_INPUTS  = 256,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     op_i,
  output logic                     in_stall_o,
  input  logic                     cfg_clr_i,
  input  logic [$clog2(MAX_INPUTS+1)-1:0] eff_len_i,
  input  logic [imm_pkg::CNT_W-1:0] eff_cnt_i,
  input  logic                     layout_i,
  input  logic                     out_free_i,
  output imm_pkg::ctrl_t           ctrl_o,
  output logic [((MAX_INPUTS*MAX_OUTPUTS > 1) ? $clog2(MAX_INPUTS*MAX_OUTPUTS) : 1)-1:0]
                                   w_waddr_o,
  output logic [((MAX_INPUTS*MAX_OUTPUTS > 1) ? $clog2(MAX_INPUTS*MAX_OUTPUTS) : 1)-1:0]
                                   w_raddr_o
);

  localparam int STORE_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW  = $clog2(MAX_INPUTS + 1);
  localparam int KW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int XW  = SAW + 8;

  imm_pkg::seq_state_e state_q, state_d;
  logic [imm_pkg::IDX_W-1:0] j_q, j_d;
  logic [KW-1:0]  k_q, k_d;
  logic [SAW-1:0] base_q, base_d;   // k * cnt, start address for transposed layout
  logic [SAW-1:0] addr_q, addr_d;
  logic [SAW-1:0] p_q, p_d;
  logic           last_row_q, last_row_d;

  logic [XW-1:0]  total;
  logic [XW-1:0]  p_inc;
  logic [SAW-1:0] stride;
  logic           accept;
  logic           j_last;

  assign total  = XW'(eff_len_i) * XW'(eff_cnt_i);
  assign p_inc  = XW'(p_q) + XW'(1);
  assign stride = layout_i ? SAW'(1) : SAW'(eff_len_i);
  assign j_last = ({1'b0, j_q} == (eff_cnt_i - imm_pkg::CNT_W'(1)));

  assign in_stall_o = (state_q != imm_pkg::S_IDLE);
  assign accept     = in_valid_i && (state_q == imm_pkg::S_IDLE);
  assign w_waddr_o  = p_q;
  assign w_raddr_o  = addr_q;

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    k_d        = k_q;
    base_d     = base_q;
    addr_d     = addr_q;
    p_d        = p_q;
    last_row_d = last_row_q;
    ctrl_o          = '0;
    ctrl_o.j        = j_q;
    ctrl_o.j_last   = j_last;
    ctrl_o.row_end  = last_row_q;

    case (state_q)
      imm_pkg::S_IDLE: begin
        if (accept && (imm_pkg::op_e'(op_i) == imm_pkg::OP_WEIGHT)) begin
          ctrl_o.w_load = 1'b1;
          p_d = (p_inc >= total) ? '0 : SAW'(p_inc);
        end else if (accept) begin
          ctrl_o.act_take = 1'b1;
          j_d        = '0;
          addr_d     = layout_i ? base_q : SAW'(k_q);
          last_row_d = (LW'(k_q) == (eff_len_i - LW'(1)));
          state_d    = imm_pkg::S_RD;
        end
      end
      imm_pkg::S_RD: begin
        // a row-final step writes the output register, so it must be free
        if (!last_row_q || out_free_i) begin
          ctrl_o.rd_issue = 1'b1;
          state_d = imm_pkg::S_MAC;
        end
      end
      imm_pkg::S_MAC: begin
        ctrl_o.mac_en = 1'b1;
        if (j_last) begin
          state_d = imm_pkg::S_IDLE;
          if (last_row_q) begin
            k_d    = '0;
            base_d = '0;
          end else begin
            k_d    = k_q + KW'(1);
            base_d = base_q + SAW'(eff_cnt_i);
          end
        end else begin
          j_d     = j_q + imm_pkg::IDX_W'(1);
          addr_d  = addr_q + stride;
          state_d = imm_pkg::S_RD;
        end
      end
      default: begin
        state_d = imm_pkg::S_IDLE;
      end
    endcase

    if (cfg_clr_i) begin
      k_d    = '0;
      base_d = '0;
      p_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= imm_pkg::S_IDLE;
      j_q        <= '0;
      k_q        <= '0;
      base_q     <= '0;
      addr_q     <= '0;
      p_q        <= '0;
      last_row_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      j_q        <= j_d;
      k_q        <= k_d;
      base_q     <= base_d;
      addr_q     <= addr_d;
      p_q        <= p_d;
      last_row_q <= last_row_d;
    end
  end

endmodule

// File: design/int8_matrix_multiply.sv
// int8 x int8 matrix product with 32-bit wrapping accumulation (top level).
// Depends on imm_pkg, imm_ram, imm_seq and int8_matrix_multiply_assert.svh.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): each transaction carries op_i and
//    element_value_i. op_i = weight loads the next weight byte at the load
//    position (row-major for layout 0, transposed for layout 1), and weight
//    transactions may run back to back. op_i = activation
//    feeds the next element of the current activation row.
//  - An activation transaction occupies the block for cnt read/MAC steps
//    (cnt = effective output_count): one shared 8x8 multiply / 32-bit add
//    unit steps through the outputs, each step a registered RAM read of the
//    weight and accumulator followed by the MAC and write-back.
//  - On the row's final element each MAC step loads the output register
//    instead of writing back, so results appear in output order, one per
//    read/MAC step; last_o marks the final output of the row.
//  - Output channel (out_valid_o / out_stall_i): a stall holds the output
//    register and pauses the sequencer before a row-final read; nothing is lost.
//  - Config port: write only while idle. Any write to a listed register
//    restarts the row, the load position and clears the accumulators.
//  - Reset: registers go to 256 / 64 / 0, positions zero, accumulators read
//    as zero (valid bits). The weight store is not cleared.
`include "int8_matrix_multiply_assert.svh"
module int8_matrix_multiply #(
  parameter int MAX_INPUTS  = 256,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic signed [imm_pkg::ELEM_W-1:0]     element_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [imm_pkg::SUM_W-1:0]      sum_value_o,
  output logic [imm_pkg::IDX_W-1:0]             output_index_o,
  output logic                                  last_o,
  input  logic                                  cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]             cfg_data_i
);

  localparam int STORE_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW  = $clog2(MAX_INPUTS + 1);
  localparam int LCW = (LW > imm_pkg::CFG_W) ? LW : imm_pkg::CFG_W;
  localparam int OAW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  // configuration registers
  logic [imm_pkg::CFG_W-1:0] len_q;
  logic [imm_pkg::CNT_W-1:0] cnt_q;
  logic                      layout_q;
  logic                      cfg_clr;

  logic [LW-1:0]             eff_len;
  logic [imm_pkg::CNT_W-1:0] eff_cnt;

  imm_pkg::ctrl_t ctrl;
  logic [SAW-1:0] w_waddr, w_raddr;
  logic           out_free;

  // datapath
  logic signed [imm_pkg::ELEM_W-1:0]   a_q;
  logic [imm_pkg::ELEM_W-1:0]          w_rdata;
  logic [imm_pkg::SUM_W-1:0]           acc_rdata;
  logic                                acc_hit_q;
  logic [MAX_OUTPUTS-1:0]              acc_vld_q;
  logic signed [2*imm_pkg::ELEM_W-1:0] prod;
  logic [imm_pkg::SUM_W-1:0]           acc_base;
  logic [imm_pkg::SUM_W-1:0]           sum;

  // output register
  logic                      out_vld_q;
  logic [imm_pkg::SUM_W-1:0] sum_q;
  logic [imm_pkg::IDX_W-1:0] idx_q;
  logic                      last_q;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_clr = 1'b0;
    if (cfg_we_i) begin
      case (imm_pkg::cfg_reg_e'(cfg_index_i))
        imm_pkg::CFG_INPUT_LENGTH,
        imm_pkg::CFG_OUTPUT_COUNT,
        imm_pkg::CFG_WEIGHT_LAYOUT: cfg_clr = 1'b1;
        default:                    cfg_clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= imm_pkg::CFG_W'(256);
      cnt_q    <= imm_pkg::CNT_W'(64);
      layout_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (imm_pkg::cfg_reg_e'(cfg_index_i))
        imm_pkg::CFG_INPUT_LENGTH:  len_q    <= cfg_data_i;
        imm_pkg::CFG_OUTPUT_COUNT:  cnt_q    <= cfg_data_i[imm_pkg::CNT_W-1:0];
        imm_pkg::CFG_WEIGHT_LAYOUT: layout_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturate lengths into 1..MAX
  always_comb begin
    if (len_q == '0) begin
      eff_len = LW'(1);
    end else if (LCW'(len_q) > LCW'(MAX_INPUTS)) begin
      eff_len = LW'(MAX_INPUTS);
    end else begin
      eff_len = LW'(len_q);
    end
    if (cnt_q == '0) begin
      eff_cnt = imm_pkg::CNT_W'(1);
    end else if (cnt_q > imm_pkg::CNT_W'(MAX_OUTPUTS)) begin
      eff_cnt = imm_pkg::CNT_W'(MAX_OUTPUTS);
    end else begin
      eff_cnt = cnt_q;
    end
  end

  // ------------------------------------------------------------- sequencer
  assign out_free = !out_vld_q || !out_stall_i;

  imm_seq #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .cfg_clr_i  (cfg_clr),
    .eff_len_i  (eff_len),
    .eff_cnt_i  (eff_cnt),
    .layout_i   (layout_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .w_waddr_o  (w_waddr),
    .w_raddr_o  (w_raddr)
  );

  // --------------------------------------------------------------- storage
  imm_ram #(
    .WIDTH (imm_pkg::ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.w_load),
    .waddr_i (w_waddr),
    .wdata_i (element_value_i),
    .re_i    (ctrl.rd_issue),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // row-final steps skip the write-back; the valid bit clears instead
  imm_ram #(
    .WIDTH (imm_pkg::SUM_W),
    .DEPTH (MAX_OUTPUTS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.mac_en && !ctrl.row_end),
    .waddr_i (ctrl.j[OAW-1:0]),
    .wdata_i (sum),
    .re_i    (ctrl.rd_issue),
    .raddr_i (ctrl.j[OAW-1:0]),
    .rdata_o (acc_rdata)
  );

  // accumulator valid bits: an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (cfg_clr) begin
      acc_vld_q <= '0;
    end else if (ctrl.mac_en) begin
      acc_vld_q[ctrl.j[OAW-1:0]] <= !ctrl.row_end;
    end
  end

  // ------------------------------------------------------------------- MAC
  always_ff @(posedge clk_i) begin
    if (ctrl.act_take) begin
      a_q <= element_value_i;
    end
    if (ctrl.rd_issue) begin
      acc_hit_q <= acc_vld_q[ctrl.j[OAW-1:0]];
    end
  end

  assign prod     = a_q * $signed(w_rdata);
  assign acc_base = acc_hit_q ? acc_rdata : '0;
  assign sum      = acc_base + {{(imm_pkg::SUM_W - 2*imm_pkg::ELEM_W){prod[15]}}, prod};

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.mac_en && ctrl.row_end) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.mac_en && ctrl.row_end) begin
      sum_q  <= sum;
      idx_q  <= ctrl.j;
      last_q <= ctrl.j_last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sum_value_o    = sum_q;
  assign output_index_o = idx_q;
  assign last_o         = last_q;

  // ------------------------------------------------------------ assertions
  `IMM_ASSERT_IMP(a_out_reg_free, ctrl.mac_en && ctrl.row_end, !out_vld_q)
  `IMM_ASSERT_NXT(a_read_then_mac, ctrl.rd_issue, ctrl.mac_en)
  `IMM_ASSERT_NXT(a_row_last_flag, ctrl.mac_en && ctrl.row_end && ctrl.j_last,
                  out_valid_o && last_o)
  `IMM_ASSERT_NXT(a_cfg_clears_acc, cfg_clr, acc_vld_q == '0)

endmodule
